FILE: src/bhpq_pkg.sv
// Shared types and constants for the binary heap priority queue.
// No dependencies; every other file in src except bhpq_ram imports this package.
`timescale 1ns / 1ps

package bhpq_pkg;

  localparam int unsigned SlotsDefault     = 256;
  localparam int unsigned ValueBitsDefault = 8;
  localparam int unsigned KeyW             = 32;
  localparam int unsigned ValW             = 8;
  localparam int unsigned CountW           = 8;
  localparam int unsigned StatusW          = 2;

  typedef enum logic [StatusW-1:0] {
    StatusOk    = 2'd0,
    StatusFull  = 2'd1,
    StatusEmpty = 2'd2
  } status_e;

  typedef enum logic {
    OpInsert = 1'b0,
    OpDelete = 1'b1
  } opcode_e;

  typedef enum logic [3:0] {
    StIdle,
    StInsRd,
    StInsCmp,
    StDelTop,
    StDelLast,
    StDelCur,
    StSiftL,
    StSiftR,
    StSiftCmp,
    StFin
  } state_e;

endpackage

FILE: src/binary_heap_priority_queue_core.sv
// Binary heap priority queue, top level: mode register, storage, comparator, sequencer.
// Depends on bhpq_pkg, bhpq_ram, bhpq_cmp and bhpq_seq.
`timescale 1ns / 1ps

// Priority queue of key/value entries held as a one-based binary heap in a
// single-port-write, single-port-read RAM. max_mode (cfg_we_i/cfg_wdata_i)
// selects max-heap (1) or min-heap (0); write it only while the queue is idle.
// opcode 0 inserts, 1 removes the top entry; every transaction yields one
// result with status, removed entry (zero unless a delete succeeded) and the
// fill count. Items are taken one at a time: in_ready_o is high only between
// operations. Errors (insert when full, delete when empty) go straight to the
// finish state. An insert reads the parent and compares at each level it climbs;
// a delete reads the top and the last entry, then at each level it sinks reads
// the left and then the right child, since the RAM has one read port. Capacity
// is SLOTS-1.
// A finished result waits in an output register without stalling the next
// accept, and no clearing pass follows reset.
module binary_heap_priority_queue_core #(
  parameter int unsigned SLOTS      = bhpq_pkg::SlotsDefault,
  parameter int unsigned VALUE_BITS = bhpq_pkg::ValueBitsDefault
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic                              cfg_wdata_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              opcode_i,
  input  logic signed [bhpq_pkg::KeyW-1:0]  entry_key_i,
  input  logic [bhpq_pkg::ValW-1:0]         entry_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bhpq_pkg::StatusW-1:0]      status_o,
  output logic signed [bhpq_pkg::KeyW-1:0]  top_key_o,
  output logic [bhpq_pkg::ValW-1:0]         top_value_o,
  output logic [bhpq_pkg::CountW-1:0]       entry_count_o
);

  import bhpq_pkg::*;

  localparam int unsigned AW  = $clog2(SLOTS);
  localparam int unsigned SVB = (VALUE_BITS < ValW) ? VALUE_BITS : ValW;
  localparam int unsigned EW  = KeyW + SVB;

  logic                    max_mode_q;
  logic                    wr_en;
  logic [AW-1:0]           wr_addr;
  logic [EW-1:0]           wr_data;
  logic [AW-1:0]           rd_addr;
  logic [EW-1:0]           rd_data;
  logic signed [KeyW-1:0]  cmp_upper;
  logic signed [KeyW-1:0]  cmp_lower;
  logic                    cmp_loses;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_mode_q <= 1'b0;
    end else if (cfg_we_i) begin
      max_mode_q <= cfg_wdata_i;
    end
  end

  bhpq_ram #(
    .DEPTH (SLOTS),
    .WIDTH (EW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  bhpq_cmp u_cmp (
    .max_mode_i (max_mode_q),
    .upper_i    (cmp_upper),
    .lower_i    (cmp_lower),
    .loses_o    (cmp_loses)
  );

  bhpq_seq #(
    .SLOTS      (SLOTS),
    .VALUE_BITS (VALUE_BITS)
  ) u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .opcode_i      (opcode_i),
    .entry_key_i   (entry_key_i),
    .entry_value_i (entry_value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_o      (status_o),
    .top_key_o     (top_key_o),
    .top_value_o   (top_value_o),
    .entry_count_o (entry_count_o),
    .wr_en_o       (wr_en),
    .wr_addr_o     (wr_addr),
    .wr_data_o     (wr_data),
    .rd_addr_o     (rd_addr),
    .rd_data_i     (rd_data),
    .cmp_upper_o   (cmp_upper),
    .cmp_lower_o   (cmp_lower),
    .cmp_loses_i   (cmp_loses)
  );

endmodule

FILE: src/bhpq_ram.sv
// Heap entry storage: one write port, one read port with registered data.
// Depends on nothing; sized by the top level's parameters.
`timescale 1ns / 1ps

module bhpq_ram #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned WIDTH = 40,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AW-1:0]    wr_addr_i,
  input  logic [WIDTH-1:0] wr_data_i,
  input  logic [AW-1:0]    rd_addr_i,
  output logic [WIDTH-1:0] rd_data_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: src/bhpq_cmp.sv
// Shared key comparator: tells whether the upper entry must give way.
// Depends on bhpq_pkg for the key width.
`timescale 1ns / 1ps

module bhpq_cmp (
  input  logic                               max_mode_i,
  input  logic signed [bhpq_pkg::KeyW-1:0]   upper_i,
  input  logic signed [bhpq_pkg::KeyW-1:0]   lower_i,
  output logic                               loses_o
);

  import bhpq_pkg::*;

  // ties never lose, so equal keys do not move past each other
  assign loses_o = max_mode_i ? (upper_i < lower_i) : (upper_i > lower_i);

endmodule

FILE: src/bhpq_seq.sv
// Sequencer and datapath: sift-up on insert, sift-down on delete, result register.
// Depends on bhpq_pkg; drives bhpq_ram and bhpq_cmp through the top level.
`timescale 1ns / 1ps

module bhpq_seq #(
  parameter int unsigned SLOTS      = bhpq_pkg::SlotsDefault,
  parameter int unsigned VALUE_BITS = bhpq_pkg::ValueBitsDefault,
  localparam int unsigned AW  = $clog2(SLOTS),
  localparam int unsigned SVB = (VALUE_BITS < bhpq_pkg::ValW) ? VALUE_BITS : bhpq_pkg::ValW,
  localparam int unsigned EW  = bhpq_pkg::KeyW + SVB
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              opcode_i,
  input  logic signed [bhpq_pkg::KeyW-1:0]  entry_key_i,
  input  logic [bhpq_pkg::ValW-1:0]         entry_value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [bhpq_pkg::StatusW-1:0]      status_o,
  output logic signed [bhpq_pkg::KeyW-1:0]  top_key_o,
  output logic [bhpq_pkg::ValW-1:0]         top_value_o,
  output logic [bhpq_pkg::CountW-1:0]       entry_count_o,
  output logic                              wr_en_o,
  output logic [AW-1:0]                     wr_addr_o,
  output logic [EW-1:0]                     wr_data_o,
  output logic [AW-1:0]                     rd_addr_o,
  input  logic [EW-1:0]                     rd_data_i,
  output logic signed [bhpq_pkg::KeyW-1:0]  cmp_upper_o,
  output logic signed [bhpq_pkg::KeyW-1:0]  cmp_lower_o,
  input  logic                              cmp_loses_i
);

  import bhpq_pkg::*;

  state_e         state_q, state_d;
  status_e        status_q, status_d;
  logic [AW-1:0]  count_q, count_d;
  logic [AW-1:0]  pos_q, pos_d;
  logic [EW-1:0]  cur_q, cur_d;
  logic [EW-1:0]  top_q, top_d;
  logic [EW-1:0]  best_q, best_d;
  logic [AW-1:0]  best_idx_q, best_idx_d;
  logic           best_child_q, best_child_d;

  logic                  out_valid_q, out_valid_d;
  status_e               out_status_q, out_status_d;
  logic [EW-1:0]         out_top_q, out_top_d;
  logic [AW-1:0]         out_count_q, out_count_d;

  logic [AW:0]    l_idx, r_idx, cnt_ext;
  logic           l_ok, r_ok, full, out_load;
  logic           fin_child;
  logic [EW-1:0]  fin_ent;
  logic [AW-1:0]  fin_idx;

  assign cnt_ext = {1'b0, count_q};
  assign l_idx   = {pos_q, 1'b0};
  assign r_idx   = l_idx + (AW+1)'(1);
  assign l_ok    = l_idx <= cnt_ext;
  assign r_ok    = r_idx <= cnt_ext;
  assign full    = count_q == AW'(SLOTS - 1);

  // pick the winner among current holder, left child and right child
  always_comb begin
    fin_child = best_child_q;
    fin_ent   = best_q;
    fin_idx   = best_idx_q;
    if (r_ok && cmp_loses_i) begin
      fin_child = 1'b1;
      fin_ent   = rd_data_i;
      fin_idx   = r_idx[AW-1:0];
    end
  end

  assign out_load = (state_q == StFin) && (!out_valid_q || out_ready_i);

  always_comb begin
    state_d      = state_q;
    status_d     = status_q;
    count_d      = count_q;
    pos_d        = pos_q;
    cur_d        = cur_q;
    top_d        = top_q;
    best_d       = best_q;
    best_idx_d   = best_idx_q;
    best_child_d = best_child_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    out_status_d = out_status_q;
    out_top_d    = out_top_q;
    out_count_d  = out_count_q;
    wr_en_o      = 1'b0;
    wr_addr_o    = pos_q;
    wr_data_o    = cur_q;
    rd_addr_o    = pos_q;
    cmp_upper_o  = cur_q[EW-1 -: KeyW];
    cmp_lower_o  = rd_data_i[EW-1 -: KeyW];
    in_ready_o   = state_q == StIdle;

    case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          cur_d    = {entry_key_i, entry_value_i[SVB-1:0]};
          top_d    = '0;
          status_d = StatusOk;
          if (opcode_i == OpInsert) begin
            if (full) begin
              status_d = StatusFull;
              state_d  = StFin;
            end else begin
              count_d = count_q + AW'(1);
              pos_d   = count_q + AW'(1);
              state_d = StInsRd;
            end
          end else begin
            if (count_q == '0) begin
              status_d = StatusEmpty;
              state_d  = StFin;
            end else begin
              state_d = StDelTop;
            end
          end
        end
      end
      StInsRd: begin
        if (pos_q == AW'(1)) begin
          wr_en_o = 1'b1;
          state_d = StFin;
        end else begin
          rd_addr_o = pos_q >> 1;
          state_d   = StInsCmp;
        end
      end
      StInsCmp: begin
        // parent data is on rd_data_i
        cmp_upper_o = rd_data_i[EW-1 -: KeyW];
        cmp_lower_o = cur_q[EW-1 -: KeyW];
        wr_en_o     = 1'b1;
        if (cmp_loses_i) begin
          wr_data_o = rd_data_i;
          pos_d     = pos_q >> 1;
          state_d   = StInsRd;
        end else begin
          state_d = StFin;
        end
      end
      StDelTop: begin
        rd_addr_o = AW'(1);
        state_d   = StDelLast;
      end
      StDelLast: begin
        rd_addr_o = count_q;
        top_d     = rd_data_i;
        state_d   = StDelCur;
      end
      StDelCur: begin
        cur_d   = rd_data_i;
        count_d = count_q - AW'(1);
        pos_d   = AW'(1);
        state_d = StSiftL;
      end
      StSiftL: begin
        if (l_ok) begin
          rd_addr_o = l_idx[AW-1:0];
          state_d   = StSiftR;
        end else begin
          wr_en_o = 1'b1;
          state_d = StFin;
        end
      end
      StSiftR: begin
        rd_addr_o = r_idx[AW-1:0];
        if (cmp_loses_i) begin
          best_d       = rd_data_i;
          best_idx_d   = l_idx[AW-1:0];
          best_child_d = 1'b1;
        end else begin
          best_d       = cur_q;
          best_idx_d   = pos_q;
          best_child_d = 1'b0;
        end
        state_d = StSiftCmp;
      end
      StSiftCmp: begin
        cmp_upper_o = best_q[EW-1 -: KeyW];
        wr_en_o     = 1'b1;
        if (fin_child) begin
          wr_data_o = fin_ent;
          pos_d     = fin_idx;
          state_d   = StSiftL;
        end else begin
          state_d = StFin;
        end
      end
      StFin: begin
        if (out_load) begin
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_top_d    = top_q;
          out_count_d  = count_q;
          state_d      = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q     <= status_d;
    pos_q        <= pos_d;
    cur_q        <= cur_d;
    top_q        <= top_d;
    best_q       <= best_d;
    best_idx_q   <= best_idx_d;
    best_child_q <= best_child_d;
    out_status_q <= out_status_d;
    out_top_q    <= out_top_d;
    out_count_q  <= out_count_d;
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign top_key_o     = out_top_q[EW-1 -: KeyW];
  assign top_value_o   = ValW'(out_top_q[SVB-1:0]);
  assign entry_count_o = CountW'(out_count_q);

`ifndef SYNTHESIS
  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle && in_valid_i && opcode_i == OpInsert && !full)
      |=> count_q == $past(count_q) + AW'(1))
    else $error("insert did not grow the fill count");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && status_q == StatusFull) |-> full)
    else $error("full status reported with free slots");

  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && status_q == StatusEmpty) |-> count_q == '0)
    else $error("empty status reported with live entries");

  a_write_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> (wr_addr_o != '0 && state_q != StIdle && state_q != StFin))
    else $error("heap write outside an operation or to slot zero");
`endif

endmodule
